[src/i2cmrr_pkg.sv]
// Package for the I2C register-read master: bus phase codes, state record,
// and the line-drive decode used on entry to each phase. No dependencies.
package i2cmrr_pkg;

    localparam int PhaseW = 4;

    localparam logic [PhaseW-1:0] PH_IDLE  = 4'd0;
    localparam logic [PhaseW-1:0] PH_S1    = 4'd1;
    localparam logic [PhaseW-1:0] PH_S2    = 4'd2;
    localparam logic [PhaseW-1:0] PH_S3    = 4'd3;
    localparam logic [PhaseW-1:0] PH_WLOW  = 4'd4;
    localparam logic [PhaseW-1:0] PH_WHIGH = 4'd5;
    localparam logic [PhaseW-1:0] PH_ALOW  = 4'd6;
    localparam logic [PhaseW-1:0] PH_AHIGH = 4'd7;
    localparam logic [PhaseW-1:0] PH_AEND  = 4'd8;
    localparam logic [PhaseW-1:0] PH_RHIGH = 4'd9;
    localparam logic [PhaseW-1:0] PH_RLOW  = 4'd10;
    localparam logic [PhaseW-1:0] PH_NSET  = 4'd11;
    localparam logic [PhaseW-1:0] PH_NHIGH = 4'd12;
    localparam logic [PhaseW-1:0] PH_T1    = 4'd13;
    localparam logic [PhaseW-1:0] PH_T2    = 4'd14;
    localparam logic [PhaseW-1:0] PH_T3    = 4'd15;

    // transfer index within one sequence
    localparam logic [1:0] XFER_DEV_WR = 2'd0;
    localparam logic [1:0] XFER_REG    = 2'd1;
    localparam logic [1:0] XFER_DEV_RD = 2'd2;
    localparam logic [1:0] XFER_READ   = 2'd3;

    // configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_PHASE_TICKS    = 1'b1;

    localparam logic [6:0]  DEV_ADDR_RST    = 7'd104;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
    localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [15:0]       ticks;
        logic [3:0]        bit_cnt;
        logic [1:0]        xfer;
        logic [7:0]        shift;
        logic [7:0]        reg_addr;
        logic [7:0]        result;
        logic              nack;
        logic              scl;
        logic              sda;
    } state_t;

    typedef struct packed {
        logic scl;
        logic sda;
    } drive_t;

    // Line drives on entering phase ph; unchanged lines keep cur.
    function automatic drive_t phase_drive(logic [PhaseW-1:0] ph, logic msb, drive_t cur);
        drive_t d;
        d = cur;
        case (ph)
            PH_S1:    d = '{scl: 1'b0, sda: 1'b0};
            PH_S2:    d = '{scl: 1'b0, sda: 1'b1};
            PH_S3:    d = '{scl: 1'b1, sda: 1'b1};
            PH_WLOW:  d = '{scl: 1'b1, sda: ~msb};
            PH_WHIGH: d.scl = 1'b0;
            PH_ALOW:  d = '{scl: 1'b1, sda: 1'b0};
            PH_AHIGH: d.scl = 1'b0;
            PH_AEND:  d.scl = 1'b1;
            PH_RHIGH: d = '{scl: 1'b0, sda: 1'b0};
            PH_RLOW:  d.scl = 1'b1;
            PH_NSET:  d = '{scl: 1'b1, sda: 1'b0};
            PH_NHIGH: d.scl = 1'b0;
            PH_T1:    d = '{scl: 1'b1, sda: 1'b1};
            PH_T2:    d.scl = 1'b0;
            PH_T3:    d.sda = 1'b0;
            default:  d = '{scl: 1'b0, sda: 1'b0};
        endcase
        return d;
    endfunction

endpackage

[src/i2cmrr_if.sv]
// Request and result channel interfaces for the I2C register-read master.
// Valid/ready handshake with payload; no package dependency.
interface i2cmrr_cmd_if;
    logic       valid;
    logic       ready;
    logic       go;
    logic [7:0] reg_address;
    logic       sda_in;

    modport source (output valid, go, reg_address, sda_in, input ready);
    modport sink   (input valid, go, reg_address, sda_in, output ready);
endinterface

interface i2cmrr_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       nack_seen;

    modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                    read_value, nack_seen, input ready);
    modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                    read_value, nack_seen, output ready);
endinterface

[src/i2cmrr_step.sv]
// One-tick next-state logic of the I2C register-read sequencer.
// Depends on i2cmrr_pkg.
module i2cmrr_step (
    input  i2cmrr_pkg::state_t st,
    input  logic               go,
    input  logic [7:0]         reg_address,
    input  logic               sda_in,
    input  logic [6:0]         device_address,
    input  logic [15:0]        phase_ticks,
    output i2cmrr_pkg::state_t nxt,
    output logic               done
);

    logic [15:0]                     limit;
    logic [16:0]                     tick_inc;
    logic                            step_end;
    logic                            do_enter;
    logic [i2cmrr_pkg::PhaseW-1:0]   new_ph;
    logic [3:0]                      bit_inc;
    i2cmrr_pkg::drive_t              drv;

    assign limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign tick_inc = {1'b0, st.ticks} + 17'd1;
    assign step_end = (tick_inc >= {1'b0, limit});
    assign bit_inc  = st.bit_cnt + 4'd1;

    always_comb
    begin
        nxt      = st;
        done     = 1'b0;
        do_enter = 1'b0;
        new_ph   = i2cmrr_pkg::PH_IDLE;

        if (st.phase == i2cmrr_pkg::PH_IDLE)
        begin
            if (go)
            begin
                nxt.reg_addr = reg_address;
                nxt.nack     = 1'b0;
                nxt.xfer     = i2cmrr_pkg::XFER_DEV_WR;
                nxt.bit_cnt  = 4'd0;
                new_ph       = i2cmrr_pkg::PH_S1;
                do_enter     = 1'b1;
            end
        end
        else if (!step_end)
        begin
            nxt.ticks = tick_inc[15:0];
        end
        else
        begin
            do_enter = 1'b1;
            case (st.phase)
                i2cmrr_pkg::PH_S1: new_ph = i2cmrr_pkg::PH_S2;
                i2cmrr_pkg::PH_S2: new_ph = i2cmrr_pkg::PH_S3;
                i2cmrr_pkg::PH_S3:
                begin
                    // R/W bit: write on first address, read after repeated start
                    nxt.shift   = {device_address,
                                   st.xfer != i2cmrr_pkg::XFER_DEV_WR};
                    nxt.bit_cnt = 4'd0;
                    new_ph      = i2cmrr_pkg::PH_WLOW;
                end
                i2cmrr_pkg::PH_WLOW: new_ph = i2cmrr_pkg::PH_WHIGH;
                i2cmrr_pkg::PH_WHIGH:
                begin
                    nxt.shift   = {st.shift[6:0], 1'b0};
                    nxt.bit_cnt = bit_inc;
                    new_ph      = (bit_inc >= i2cmrr_pkg::BITS_PER_BYTE)
                                  ? i2cmrr_pkg::PH_ALOW : i2cmrr_pkg::PH_WLOW;
                end
                i2cmrr_pkg::PH_ALOW: new_ph = i2cmrr_pkg::PH_AHIGH;
                i2cmrr_pkg::PH_AHIGH:
                begin
                    if (sda_in)
                        nxt.nack = 1'b1;
                    new_ph = i2cmrr_pkg::PH_AEND;
                end
                i2cmrr_pkg::PH_AEND:
                begin
                    case (st.xfer)
                        i2cmrr_pkg::XFER_DEV_WR:
                        begin
                            nxt.xfer    = i2cmrr_pkg::XFER_REG;
                            nxt.shift   = st.reg_addr;
                            nxt.bit_cnt = 4'd0;
                            new_ph      = i2cmrr_pkg::PH_WLOW;
                        end
                        i2cmrr_pkg::XFER_REG:
                        begin
                            nxt.xfer = i2cmrr_pkg::XFER_DEV_RD;
                            new_ph   = i2cmrr_pkg::PH_S1;
                        end
                        default:
                        begin
                            nxt.xfer    = i2cmrr_pkg::XFER_READ;
                            nxt.shift   = 8'd0;
                            nxt.bit_cnt = 4'd0;
                            new_ph      = i2cmrr_pkg::PH_RHIGH;
                        end
                    endcase
                end
                i2cmrr_pkg::PH_RHIGH:
                begin
                    nxt.shift   = {st.shift[6:0], sda_in};
                    nxt.bit_cnt = bit_inc;
                    new_ph      = i2cmrr_pkg::PH_RLOW;
                end
                i2cmrr_pkg::PH_RLOW:
                    new_ph = (st.bit_cnt >= i2cmrr_pkg::BITS_PER_BYTE)
                             ? i2cmrr_pkg::PH_NSET : i2cmrr_pkg::PH_RHIGH;
                i2cmrr_pkg::PH_NSET:  new_ph = i2cmrr_pkg::PH_NHIGH;
                i2cmrr_pkg::PH_NHIGH: new_ph = i2cmrr_pkg::PH_T1;
                i2cmrr_pkg::PH_T1:    new_ph = i2cmrr_pkg::PH_T2;
                i2cmrr_pkg::PH_T2:    new_ph = i2cmrr_pkg::PH_T3;
                default:
                begin
                    // end of stop condition
                    nxt.result  = st.shift;
                    nxt.xfer    = i2cmrr_pkg::XFER_DEV_WR;
                    nxt.bit_cnt = 4'd0;
                    new_ph      = i2cmrr_pkg::PH_IDLE;
                    done        = 1'b1;
                end
            endcase
        end

        drv = i2cmrr_pkg::phase_drive(new_ph, nxt.shift[7], '{scl: st.scl, sda: st.sda});
        if (do_enter)
        begin
            nxt.phase = new_ph;
            nxt.ticks = 16'd0;
            nxt.scl   = drv.scl;
            nxt.sda   = drv.sda;
        end
    end

endmodule

[src/i2c_master_register_read.sv]
// Top level of the I2C register-read master: state and result registers,
// config registers. Depends on i2cmrr_pkg, i2cmrr_if.sv, i2cmrr_step.
//
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+------------
//  cmd     | in  | go, reg_address, sda_in (one bus tick)         | valid/ready
//  rsp     | out | scl_pull_low, sda_pull_low, busy_res, done_res,| valid/ready
//          |     | read_value, nack_seen                          |
//  cfg     | in  | cfg_we, cfg_index, cfg_data                    | write only
//
// One request per clock: the sequencer state advances in the cycle a request
// is accepted and its result lands in the result register on the same edge.
// The result register is the only buffer; cmd.ready drops only while a result
// is held and rsp.ready is low. Reset clears rsp.valid and the sequencer:
// idle, drives released, result/nack zero; config address 0x68, 100 ticks.
module i2c_master_register_read (
    input  logic                clk,
    input  logic                rst_n,
    i2cmrr_cmd_if.sink          cmd,
    i2cmrr_rsp_if.source        rsp,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

    i2cmrr_pkg::state_t st_reg;
    i2cmrr_pkg::state_t st_next;
    logic               done_next;

    logic [6:0]  dev_addr_reg;
    logic [15:0] phase_ticks_reg;

    logic        rsp_valid_reg;
    logic        scl_reg;
    logic        sda_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [7:0]  read_value_reg;
    logic        nack_reg;

    logic        accept;

    // Skid-free: take a request whenever the result slot is free or draining.
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    i2cmrr_step u_step (
        .st             (st_reg),
        .go             (cmd.go),
        .reg_address    (cmd.reg_address),
        .sda_in         (cmd.sda_in),
        .device_address (dev_addr_reg),
        .phase_ticks    (phase_ticks_reg),
        .nxt            (st_next),
        .done           (done_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= i2cmrr_pkg::DEV_ADDR_RST;
            phase_ticks_reg <= i2cmrr_pkg::PHASE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == i2cmrr_pkg::CFG_DEVICE_ADDRESS)
                dev_addr_reg <= cfg_data[6:0];
            else
                phase_ticks_reg <= cfg_data;
        end
    end

    // Sequencer state: all fields reset, idle is code zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_reg        <= st_next.scl;
            sda_reg        <= st_next.sda;
            busy_reg       <= (st_next.phase != i2cmrr_pkg::PH_IDLE);
            done_reg       <= done_next;
            read_value_reg <= st_next.result;
            nack_reg       <= st_next.nack;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.scl_pull_low = scl_reg;
    assign rsp.sda_pull_low = sda_reg;
    assign rsp.busy_res     = busy_reg;
    assign rsp.done_res     = done_reg;
    assign rsp.read_value   = read_value_reg;
    assign rsp.nack_seen    = nack_reg;

    // A completed stop always leaves the sequencer idle.
    a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && done_reg |-> !busy_reg)
        else $error("done reported while busy");

    // go on an idle tick starts the sequence with a start condition.
    a_go_starts : assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.go && st_reg.phase == i2cmrr_pkg::PH_IDLE
        |=> st_reg.phase == i2cmrr_pkg::PH_S1 && !st_reg.nack)
        else $error("go did not start a sequence");

    // Bit counter never passes one byte.
    a_bit_range : assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.bit_cnt <= i2cmrr_pkg::BITS_PER_BYTE)
        else $error("bit counter out of range");

    // Idle means a clean tick counter and released lines.
    a_idle_clean : assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase == i2cmrr_pkg::PH_IDLE |-> st_reg.ticks == 16'd0
        && !st_reg.scl && !st_reg.sda)
        else $error("idle with stale timing or drive");

endmodule
